[rtl/windowed_score_fusion_defines.svh]
// Assertion macros shared by the windowed score fusion RTL
`ifndef WINDOWED_SCORE_FUSION_DEFINES_SVH
`define WINDOWED_SCORE_FUSION_DEFINES_SVH

`ifndef SYNTHESIS
`define WSF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("wsf assertion failed");
`define WSF_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("wsf forbidden condition");
`else
`define WSF_ASSERT(label, prop)
`define WSF_NEVER(label, expr)
`endif

`endif

[rtl/wsf_pkg.sv]
package wsf_pkg;

	localparam int NUM_CLIENTS = 8;
	localparam int MAX_FRAMES  = 5;

	localparam int CLIENT_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int POS_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int FILL_W   = $clog2(MAX_FRAMES + 1);
	localparam int HIST_DEPTH = NUM_CLIENTS * MAX_FRAMES;
	localparam int ADDR_W   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

	localparam int SLOT_IN_W = 3;
	localparam int ID_W      = 17;
	localparam int SIM_W     = 16;
	localparam int TIME_W    = 32;
	localparam int WIN_W     = 16;
	localparam int LIMIT_W   = 3;
	localparam int COUNT_W   = 3;

	localparam int SLOT_LSB = 0;
	localparam int ID_LSB   = SLOT_LSB + SLOT_IN_W;
	localparam int SIM_LSB  = ID_LSB + ID_W;
	localparam int TIME_LSB = SIM_LSB + SIM_W;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 56;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

	localparam logic [WIN_W-1:0]   WINDOW_RST = 16'd900;
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 3'd5;
	localparam logic [SIM_W-1:0]   THRESH_RST = 16'd45875;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [CLIENT_W-1:0]    slot;
		logic [ADDR_W-1:0]      base;
		logic signed [ID_W-1:0] id;
		logic [SIM_W-1:0]       sim;
		logic [TIME_W-1:0]      time_ms;
	} item_t;

	typedef struct packed {
		logic signed [ID_W-1:0] id;
		logic [SIM_W-1:0]       sim;
		logic [TIME_W-1:0]      time_ms;
	} entry_t;

	typedef struct packed {
		logic [WIN_W-1:0]   window_ms;
		logic [LIMIT_W-1:0] frame_limit;
		logic [SIM_W-1:0]   accept_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [ID_W-1:0] final_id;
		logic [SIM_W-1:0]       best_similarity;
		logic signed [ID_W-1:0] best_id;
		logic [COUNT_W-1:0]     best_id_count;
		logic                   accepted;
	} res_t;

	function automatic logic [CLIENT_W-1:0] slot_reduce(logic [SLOT_IN_W-1:0] s);
		int v;
		v = int'(s);
		for (int i = 0; i < 8; i++) begin
			if (v >= NUM_CLIENTS) v = v - NUM_CLIENTS;
		end
		return CLIENT_W'(v);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_base(logic [CLIENT_W-1:0] s);
		return ADDR_W'(int'(s) * MAX_FRAMES);
	endfunction

	function automatic logic [POS_W-1:0] pos_add(logic [POS_W-1:0] a, logic [FILL_W-1:0] b);
		int s;
		s = int'(a) + int'(b);
		if (s >= MAX_FRAMES) s = s - MAX_FRAMES;
		return POS_W'(s);
	endfunction

	function automatic logic [FILL_W-1:0] limit_clamp(logic [LIMIT_W-1:0] l);
		int v;
		v = int'(l);
		if (v == 0) v = 1;
		if (v > MAX_FRAMES) v = MAX_FRAMES;
		return FILL_W'(v);
	endfunction

endpackage

[rtl/wsf_front.sv]
module wsf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wsf_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            push,
	output wsf_pkg::item_t                  push_item,
	input  logic                            q_full
);
	import wsf_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_in;

	always_comb begin
		item_in.slot    = slot_reduce(s_tdata[SLOT_LSB +: SLOT_IN_W]);
		item_in.base    = slot_base(item_in.slot);
		item_in.id      = s_tdata[ID_LSB +: ID_W];
		item_in.sim     = s_tdata[SIM_LSB +: SIM_W];
		item_in.time_ms = s_tdata[TIME_LSB +: TIME_W];
	end

	assign s_tready  = !valid_s1 || !q_full;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

endmodule

[rtl/wsf_fifo.sv]
`include "windowed_score_fusion_defines.svh"

module wsf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wsf_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output wsf_pkg::item_t pop_item,
	output logic           empty
);
	import wsf_pkg::*;

	item_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_item;
	end

	`WSF_NEVER(a_q_overflow, push && full)
	`WSF_NEVER(a_q_underflow, pop && empty)

endmodule

[rtl/wsf_back.sv]
`include "windowed_score_fusion_defines.svh"

module wsf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  wsf_pkg::cfg_t  cfg,
	input  logic           q_empty,
	input  wsf_pkg::item_t q_item,
	output logic           q_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output wsf_pkg::res_t  res
);
	import wsf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AGE_RD,
		S_AGE_CHK,
		S_LIMIT,
		S_SCAN,
		S_OUT
	} state_t;

	state_t                 state_q;
	item_t                  item_q;
	logic [POS_W-1:0]       old_q;
	logic [FILL_W-1:0]      fill_q;
	logic [POS_W-1:0]       oldest_pos_q [NUM_CLIENTS];
	logic [FILL_W-1:0]      fill_count_q [NUM_CLIENTS];
	logic [FILL_W-1:0]      k_q;
	logic [FILL_W-1:0]      rx_q;
	logic                   pass_q;
	logic                   rd_vld_q;
	logic [SIM_W-1:0]       best_sim_q;
	logic signed [ID_W-1:0] best_id_q;
	logic [FILL_W-1:0]      cnt_q;
	logic                   out_valid_q;
	res_t                   out_q;

	entry_t                 hist_mem [HIST_DEPTH];
	entry_t                 ent_q;

	logic [POS_W-1:0]       cur_old;
	logic [FILL_W-1:0]      cur_fill;
	logic [POS_W-1:0]       old1;
	logic [FILL_W-1:0]      fill1;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	entry_t                 mem_wdata;
	logic                   scan_re;
	logic                   mem_re;
	logic [FILL_W-1:0]      rd_pos;
	logic [ADDR_W-1:0]      mem_raddr;
	logic [TIME_W-1:0]      age;
	logic [FILL_W-1:0]      lim;
	logic                   acc;
	logic                   res_load;

	always_comb begin
		cur_old  = oldest_pos_q[q_item.slot];
		cur_fill = fill_count_q[q_item.slot];
		if (cur_fill >= FILL_W'(MAX_FRAMES)) begin
			old1  = pos_add(cur_old, FILL_W'(1));
			fill1 = cur_fill - FILL_W'(1);
		end else begin
			old1  = cur_old;
			fill1 = cur_fill;
		end
	end

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign mem_we    = q_pop;
	assign mem_waddr = q_item.base + ADDR_W'(pos_add(old1, fill1));
	assign mem_wdata = '{id: q_item.id, sim: q_item.sim, time_ms: q_item.time_ms};

	assign scan_re   = (state_q == S_SCAN) && (k_q < fill_q);
	assign mem_re    = (state_q == S_AGE_RD) || scan_re;
	assign rd_pos    = (state_q == S_SCAN) ? k_q : '0;
	assign mem_raddr = item_q.base + ADDR_W'(pos_add(old_q, rd_pos));

	assign age = item_q.time_ms - ent_q.time_ms;
	assign lim = limit_clamp(cfg.frame_limit);
	assign acc = !best_id_q[ID_W-1] && (best_sim_q > cfg.accept_threshold);
	assign res_load = (state_q == S_OUT) && (!out_valid_q || res_ready);

	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
		if (mem_re) ent_q <= hist_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			old_q       <= '0;
			fill_q      <= '0;
			k_q         <= '0;
			rx_q        <= '0;
			pass_q      <= 1'b0;
			rd_vld_q    <= 1'b0;
			best_sim_q  <= '0;
			best_id_q   <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < NUM_CLIENTS; i++) begin
				oldest_pos_q[i] <= '0;
				fill_count_q[i] <= '0;
			end
		end else begin
			rd_vld_q <= scan_re;
			if (res_load) out_valid_q <= 1'b1;
			else if (out_valid_q && res_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						item_q  <= q_item;
						old_q   <= old1;
						fill_q  <= fill1 + FILL_W'(1);
						state_q <= S_AGE_RD;
					end
				end
				S_AGE_RD: begin
					state_q <= S_AGE_CHK;
				end
				S_AGE_CHK: begin
					if ((age > TIME_W'(cfg.window_ms)) && (fill_q != '0)) begin
						old_q   <= pos_add(old_q, FILL_W'(1));
						fill_q  <= fill_q - FILL_W'(1);
						state_q <= S_AGE_RD;
					end else begin
						state_q <= S_LIMIT;
					end
				end
				S_LIMIT: begin
					if (fill_q > lim) begin
						old_q  <= pos_add(old_q, fill_q - lim);
						fill_q <= lim;
					end
					k_q     <= '0;
					rx_q    <= '0;
					pass_q  <= 1'b0;
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (rd_vld_q && !pass_q && (rx_q == fill_q - FILL_W'(1))) begin
						pass_q <= 1'b1;
						k_q    <= '0;
						rx_q   <= '0;
					end else begin
						if (scan_re) k_q <= k_q + FILL_W'(1);
						if (rd_vld_q) rx_q <= rx_q + FILL_W'(1);
					end
					if (rd_vld_q) begin
						if (!pass_q) begin
							if ((rx_q == '0) || (ent_q.sim > best_sim_q)) begin
								best_sim_q <= ent_q.sim;
								best_id_q  <= ent_q.id;
							end
						end else if (ent_q.id == best_id_q) begin
							cnt_q <= cnt_q + FILL_W'(1);
						end
						if (pass_q && (rx_q == fill_q - FILL_W'(1))) begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (res_load) begin
						out_q.final_id        <= acc ? best_id_q : '1;
						out_q.best_similarity <= best_sim_q;
						out_q.best_id         <= best_id_q;
						out_q.best_id_count   <= COUNT_W'(cnt_q);
						out_q.accepted        <= acc;
						oldest_pos_q[item_q.slot] <= old_q;
						fill_count_q[item_q.slot] <= fill_q;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`WSF_ASSERT(a_fill_range, (state_q != S_IDLE) |-> (fill_q != '0) && (fill_q <= 3'd5))
	`WSF_ASSERT(a_count_nonzero, res_load |-> (cnt_q != '0) && (cnt_q <= fill_q))
	`WSF_NEVER(a_scan_overrun, (state_q == S_SCAN) && (rx_q > k_q))

endmodule

[rtl/windowed_score_fusion.sv]
// Path from input beat to result beat: front register, queue, then the back sequencer, which
// handles one item at a time; the front register and queue can take new items while it is busy.
// The back sequencer reads the history memory once per age check and twice per kept entry
// (max pass, count pass); each client keeps 1 to 5 entries.
// Reset: histories empty, registers at 900 / 5 / 45875; history memory is not cleared.
`include "windowed_score_fusion_defines.svh"

module windowed_score_fusion (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// client_slot[2:0], candidate_id[19:3], similarity[35:20], time_ms[67:36], zero pad
	input  logic [wsf_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// final_id[16:0], best_similarity[32:17], best_id[49:33], best_id_count[52:50],
	// accepted[53], zero pad
	output logic [wsf_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                             cfg_we,
	input  logic [wsf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [wsf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import wsf_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	item_t push_item;
	logic  q_full;
	logic  q_pop;
	item_t q_item;
	logic  q_empty;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms        <= WINDOW_RST;
			cfg_q.frame_limit      <= LIMIT_RST;
			cfg_q.accept_threshold <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW: cfg_q.window_ms        <= cfg_wdata[WIN_W-1:0];
				REG_LIMIT:  cfg_q.frame_limit      <= cfg_wdata[LIMIT_W-1:0];
				REG_THRESH: cfg_q.accept_threshold <= cfg_wdata[SIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	wsf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_item),
		.empty     (q_empty)
	);

	wsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {2'b00, res.accepted, res.best_id_count, res.best_id,
		res.best_similarity, res.final_id};

	`WSF_ASSERT(a_accept_consistent, m_tvalid |-> (res.final_id == (res.accepted ? res.best_id : '1)))

endmodule

[test/fusion_check_pkg.sv]
`timescale 1ns / 100ps

package fusion_check_pkg;

	import wsf_pkg::*;

	typedef struct packed {
		logic [SLOT_IN_W-1:0]   slot;
		logic signed [ID_W-1:0] id;
		logic [SIM_W-1:0]       sim;
		logic [TIME_W-1:0]      stamp;
	} score_in_t;

	localparam int OUT_FINAL_LSB = 0;
	localparam int OUT_SIM_LSB   = OUT_FINAL_LSB + ID_W;
	localparam int OUT_BEST_LSB  = OUT_SIM_LSB + SIM_W;
	localparam int OUT_COUNT_LSB = OUT_BEST_LSB + ID_W;
	localparam int OUT_ACC_LSB   = OUT_COUNT_LSB + COUNT_W;

	class fusion_scoreboard_t;
		logic [WIN_W-1:0]   window_ms;
		logic [LIMIT_W-1:0] frame_limit;
		logic [SIM_W-1:0]   threshold;
		entry_t             score_hist[NUM_CLIENTS][$];
		res_t               verdict_q[$];
		int                 mismatches;

		function new();
			window_ms   = WINDOW_RST;
			frame_limit = LIMIT_RST;
			threshold   = THRESH_RST;
			mismatches  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_WINDOW: window_ms = value[WIN_W-1:0];
				REG_LIMIT:  frame_limit = value[LIMIT_W-1:0];
				REG_THRESH: threshold = value[SIM_W-1:0];
				default: ;
			endcase
		endfunction

		function int verdicts_due();
			return verdict_q.size();
		endfunction

		// Append, age out from the oldest end, trim to the limit, then pick and count.
		function void note_score(score_in_t it);
			int                     slot;
			int                     keep;
			int                     count;
			logic [TIME_W-1:0]      age;
			logic [SIM_W-1:0]       best_sim;
			logic signed [ID_W-1:0] best_id;
			entry_t                 e;
			res_t                   want;
			slot = int'(it.slot) % NUM_CLIENTS;
			e.id = it.id;
			e.sim = it.sim;
			e.time_ms = it.stamp;
			score_hist[slot].insert(score_hist[slot].size(), e);
			if (score_hist[slot].size() > MAX_FRAMES)
				score_hist[slot].delete(0);
			while (score_hist[slot].size() > 0) begin
				age = it.stamp - score_hist[slot][0].time_ms;
				if (age > TIME_W'(window_ms))
					score_hist[slot].delete(0);
				else
					break;
			end
			keep = int'(frame_limit);
			if (keep == 0)
				keep = 1;
			if (keep > MAX_FRAMES)
				keep = MAX_FRAMES;
			while (score_hist[slot].size() > keep)
				score_hist[slot].delete(0);
			best_sim = score_hist[slot][0].sim;
			best_id = score_hist[slot][0].id;
			for (int k = 1; k < score_hist[slot].size(); k++) begin
				if (score_hist[slot][k].sim > best_sim) begin
					best_sim = score_hist[slot][k].sim;
					best_id = score_hist[slot][k].id;
				end
			end
			count = 0;
			for (int k = 0; k < score_hist[slot].size(); k++) begin
				if (score_hist[slot][k].id == best_id)
					count++;
			end
			want.best_similarity = best_sim;
			want.best_id = best_id;
			want.best_id_count = COUNT_W'(count);
			want.accepted = !best_id[ID_W-1] && (best_sim > threshold);
			want.final_id = want.accepted ? best_id : -17'sd1;
			verdict_q.insert(verdict_q.size(), want);
		endfunction

		function void check_verdict(logic [OUT_TDATA_W-1:0] beat);
			res_t got;
			res_t want;
			got.final_id = beat[OUT_FINAL_LSB +: ID_W];
			got.best_similarity = beat[OUT_SIM_LSB +: SIM_W];
			got.best_id = beat[OUT_BEST_LSB +: ID_W];
			got.best_id_count = beat[OUT_COUNT_LSB +: COUNT_W];
			got.accepted = beat[OUT_ACC_LSB];
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: final_id=%0d sim=%0d best_id=%0d count=%0d acc=%0b",
						got.final_id, got.best_similarity, got.best_id, got.best_id_count,
						got.accepted);
				return;
			end
			want = verdict_q[0];
			verdict_q.delete(0);
			if (got.final_id !== want.final_id || got.best_similarity !== want.best_similarity ||
					got.best_id !== want.best_id || got.best_id_count !== want.best_id_count ||
					got.accepted !== want.accepted) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch expected: final_id=%0d sim=%0d best_id=%0d count=%0d acc=%0b",
						want.final_id, want.best_similarity, want.best_id, want.best_id_count,
						want.accepted);
					$display("         actual:   final_id=%0d sim=%0d best_id=%0d count=%0d acc=%0b",
						got.final_id, got.best_similarity, got.best_id, got.best_id_count,
						got.accepted);
				end
			end
		endfunction
	endclass

endpackage

[test/windowed_score_fusion_test.sv]
`timescale 1ns / 100ps

module windowed_score_fusion_test;

	import wsf_pkg::*;
	import fusion_check_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_STRIDE, RX_CHOKE} rx_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_idx;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	fusion_scoreboard_t fusion_sb;
	int                 burst_left;
	logic [SIM_W-1:0]   last_sim;
	logic [TIME_W-1:0]  slot_clock[NUM_CLIENTS];

	windowed_score_fusion u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			fusion_sb.check_verdict(m_tdata);
	end

	initial begin
		rx_mode_t mode;
		int       span;
		int       tick;
		m_tready = 1'b0;
		tick = 0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
					RX_STRIDE: m_tready <= (tick % 4 == 0);
					RX_CHOKE:  m_tready <= (tick % 17 == 16);
					default:   m_tready <= 1'b1;
				endcase
			end
		end
	end

	task automatic offer(input logic [SLOT_IN_W-1:0] slot, input logic signed [ID_W-1:0] id,
			input logic [SIM_W-1:0] sim, input logic [TIME_W-1:0] stamp);
		score_in_t it;
		int        gap;
		it.slot = slot;
		it.id = id;
		it.sim = sim;
		it.stamp = stamp;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, it.stamp, it.sim, it.id, it.slot};
		do @(posedge clk); while (!s_tready);
		fusion_sb.note_score(it);
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (fusion_sb.verdicts_due() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		fusion_sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [WIN_W-1:0] window, input logic [LIMIT_W-1:0] limit,
			input logic [SIM_W-1:0] thresh);
		settle();
		write_reg(REG_WINDOW, window);
		write_reg(REG_LIMIT, {13'($urandom), limit});
		write_reg(REG_THRESH, thresh);
		write_reg(REG_SPARE, 16'($urandom));
	endtask

	task automatic run_phase(input logic [WIN_W-1:0] window, input logic [LIMIT_W-1:0] limit,
			input logic [SIM_W-1:0] thresh, input int items);
		int                     slot;
		int                     step;
		int                     v;
		logic signed [ID_W-1:0] base_id;
		logic signed [ID_W-1:0] id;
		logic [SIM_W-1:0]       sim;
		configure(window, limit, thresh);
		for (int s = 0; s < NUM_CLIENTS; s++)
			slot_clock[s] = ($urandom_range(0, 3) == 0) ?
				32'hFFFF_FFFF - 32'($urandom_range(0, 2000)) : $urandom;
		base_id = $urandom_range(0, 1) ? 17'sd65528 : 17'sd0;
		repeat (items) begin
			slot = $urandom_range(0, NUM_CLIENTS - 1);
			if ($urandom_range(0, 99) < 85) begin
				case ($urandom_range(0, 9))
					7:       step = 0;
					8:       step = int'(window);
					9:       step = int'(window) + $urandom_range(1, 1000);
					default: step = $urandom_range(0, int'(window) / 3);
				endcase
				slot_clock[slot] += TIME_W'(step);
				id = ($urandom_range(0, 9) == 0) ? -17'sd1 : base_id + 17'($urandom_range(0, 3));
				case ($urandom_range(0, 4))
					0: sim = 16'($urandom);
					1: begin
						v = int'(thresh) + $urandom_range(0, 4) - 2;
						if (v < 0)
							v = 0;
						if (v > 65535)
							v = 65535;
						sim = 16'(v);
					end
					2: sim = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					default: sim = last_sim;
				endcase
				last_sim = sim;
				offer(SLOT_IN_W'(slot), id, sim, slot_clock[slot]);
			end else begin
				offer(SLOT_IN_W'(slot), 17'($urandom), 16'($urandom), $urandom);
			end
		end
	endtask

	initial begin
		fusion_sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_WINDOW;
		cfg_wdata = '0;
		burst_left = 0;
		last_sim = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		offer(3'd0, 17'sd0, 16'd0, 32'd0);
		offer(3'd0, 17'sd65535, 16'd65535, 32'd100);
		offer(3'd1, 17'sd7, 16'd45875, 32'd0);
		offer(3'd2, 17'sd7, 16'd45876, 32'd0);
		offer(3'd3, -17'sd1, 16'd65535, 32'd0);
		offer(3'd4, 17'sd10, 16'd50000, 32'd0);
		offer(3'd4, 17'sd11, 16'd50000, 32'd1);
		offer(3'd4, 17'sd10, 16'd1, 32'd2);
		for (int k = 0; k < 6; k++)
			offer(3'd5, 17'sd3, 16'(46000 + 1000 * k), 32'(10 * k));
		offer(3'd6, 17'sd1, 16'd60000, 32'hFFFF_FF00);
		offer(3'd6, 17'sd2, 16'd100, 32'h0000_0010);
		offer(3'd6, 17'sd3, 16'd200, 32'h0000_0500);
		offer(3'd7, 17'sd2, 16'd100, 32'd1000);
		offer(3'd7, 17'sd3, 16'd65000, 32'd1800);
		offer(3'd7, 17'sd2, 16'd300, 32'd1500);

		configure(16'd0, 3'd0, 16'd0);
		offer(3'd0, 17'sd5, 16'd1, 32'hFFFF_FFFF);
		offer(3'd0, 17'sd5, 16'd0, 32'hFFFF_FFFF);

		configure(16'hFFFF, 3'd7, 16'hFFFF);
		offer(3'd1, 17'sd9, 16'd65535, 32'd10);
		offer(3'd1, 17'sd65535, 16'd65535, 32'd20);

		run_phase(16'd900, 3'd5, 16'd45875, 260);
		run_phase(16'd0, 3'd3, 16'd0, 260);
		run_phase(16'hFFFF, 3'd7, 16'hFFFF, 260);
		run_phase(16'd300, 3'd1, 16'd30000, 260);
		run_phase(16'd2000, 3'd0, 16'd40000, 260);
		run_phase(16'd1500, 3'd6, 16'd50000, 260);
		run_phase(16'($urandom), 3'($urandom), 16'($urandom), 260);

		settle();
		repeat (40) @(posedge clk);
		if (fusion_sb.mismatches == 0 && fusion_sb.verdicts_due() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#8000000;
		$display("FAIL");
		$finish;
	end

endmodule
